FILE: hdl/kd45c_pkg.sv
// ============================================================================
// kd45c_pkg
// Shared types, constants and microprogram for the KD45 relation check unit.
// ============================================================================
package kd45c_pkg;

    localparam int MAX_AGENTS_DEF = 8;
    localparam int MAX_WORLDS_DEF = 32;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int AGENT_CNT_W = 4;
    localparam int WORLD_CNT_W = 6;
    localparam int CNT_W       = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_COUNT = 2'd1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] agent;
        logic [4:0] src_world;
        logic [4:0] dst_world;
    } t_in_item;

    typedef struct packed {
        logic related;
        logic kd45_holds;
        logic index_error;
    } t_out_item;

    typedef logic [3:0] t_upc;

    localparam t_upc UA_IDLE      = 4'd0;
    localparam t_upc UA_RW        = 4'd1;
    localparam t_upc UA_EMIT      = 4'd2;
    localparam t_upc UA_CLR       = 4'd3;
    localparam t_upc UA_CLR_END   = 4'd4;
    localparam t_upc UA_CHK_ROW   = 4'd5;
    localparam t_upc UA_CHK_TEST  = 4'd6;
    localparam t_upc UA_CHK_BIT   = 4'd7;
    localparam t_upc UA_CHK_COL   = 4'd8;
    localparam t_upc UA_CHK_CMP   = 4'd9;
    localparam t_upc UA_CHK_VNEXT = 4'd10;
    localparam t_upc UA_CHK_WNEXT = 4'd11;
    localparam t_upc UA_CHK_ANEXT = 4'd12;
    localparam t_upc UA_PASS      = 4'd13;
    localparam t_upc UA_FAIL      = 4'd14;

    typedef enum logic [1:0] {MEM_NONE, MEM_RD, MEM_WR} t_mem_op;
    typedef enum logic [2:0] {AD_IN, AD_ITEM, AD_ROW, AD_COL, AD_CLR} t_addr_sel;
    typedef enum logic {WD_ZERO, WD_SET} t_wdata_sel;
    typedef enum logic [1:0] {CNT_HOLD, CNT_ZERO, CNT_INC} t_cnt_op;
    typedef enum logic [2:0] {
        RES_HOLD, RES_LOAD, RES_REL, RES_HOLDS, RES_BOOT_OFF
    } t_res_op;
    typedef enum logic [3:0] {
        FL_ONE, FL_ACCEPT, FL_CLR_LAST, FL_BOOT, FL_OUT_FREE, FL_ROW_ZERO,
        FL_VBIT, FL_MISMATCH, FL_V_LAST, FL_W_LAST, FL_A_LAST
    } t_flag_sel;
    typedef enum logic {JK_BRANCH, JK_DISPATCH} t_jump;

    typedef struct packed {
        logic       take_in;
        logic       emit;
        t_mem_op    mem_op;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        t_cnt_op    a_op;
        t_cnt_op    w_op;
        t_cnt_op    v_op;
        t_cnt_op    clr_op;
        logic       row_ld;
        t_res_op    res_op;
        t_jump      jump;
        t_flag_sel  flag_sel;
        t_upc       tgt_t;
        t_upc       tgt_f;
    } t_uword;

    typedef struct packed {
        logic       accept;
        logic       out_free;
        logic       clr_last;
        logic       boot;
        logic       row_zero;
        logic       vbit;
        logic       mismatch;
        logic       v_last;
        logic       w_last;
        logic       a_last;
        logic [1:0] in_op;
        logic       in_err;
        logic       vacuous;
    } t_flags;

    function automatic t_upc f_dispatch(input logic [1:0] op, input logic err,
                                        input logic vacuous);
        t_upc pc;
        case (op)
            OP_CLEAR: pc = UA_CLR;
            OP_CHECK: pc = vacuous ? UA_EMIT : UA_CHK_ROW;
            default:  pc = err ? UA_EMIT : UA_RW;
        endcase
        return pc;
    endfunction

    function automatic t_uword f_ucode(input t_upc pc);
        t_uword u;
        u.take_in   = 1'b0;
        u.emit      = 1'b0;
        u.mem_op    = MEM_NONE;
        u.addr_sel  = AD_ITEM;
        u.wdata_sel = WD_ZERO;
        u.a_op      = CNT_HOLD;
        u.w_op      = CNT_HOLD;
        u.v_op      = CNT_HOLD;
        u.clr_op    = CNT_HOLD;
        u.row_ld    = 1'b0;
        u.res_op    = RES_HOLD;
        u.jump      = JK_BRANCH;
        u.flag_sel  = FL_ONE;
        u.tgt_t     = UA_IDLE;
        u.tgt_f     = UA_IDLE;
        case (pc)
            UA_IDLE: begin
                u.take_in  = 1'b1;
                u.mem_op   = MEM_RD;
                u.addr_sel = AD_IN;
                u.a_op     = CNT_ZERO;
                u.w_op     = CNT_ZERO;
                u.v_op     = CNT_ZERO;
                u.clr_op   = CNT_ZERO;
                u.res_op   = RES_LOAD;
                u.jump     = JK_DISPATCH;
                u.tgt_f    = UA_IDLE;
            end
            UA_RW: begin
                u.mem_op    = MEM_WR;
                u.addr_sel  = AD_ITEM;
                u.wdata_sel = WD_SET;
                u.res_op    = RES_REL;
                u.emit      = 1'b1;
                u.flag_sel  = FL_OUT_FREE;
                u.tgt_t     = UA_IDLE;
                u.tgt_f     = UA_RW;
            end
            UA_EMIT: begin
                u.emit     = 1'b1;
                u.flag_sel = FL_OUT_FREE;
                u.tgt_t    = UA_IDLE;
                u.tgt_f    = UA_EMIT;
            end
            UA_CLR: begin
                u.mem_op    = MEM_WR;
                u.addr_sel  = AD_CLR;
                u.wdata_sel = WD_ZERO;
                u.clr_op    = CNT_INC;
                u.flag_sel  = FL_CLR_LAST;
                u.tgt_t     = UA_CLR_END;
                u.tgt_f     = UA_CLR;
            end
            UA_CLR_END: begin
                u.res_op   = RES_BOOT_OFF;
                u.flag_sel = FL_BOOT;
                u.tgt_t    = UA_IDLE;
                u.tgt_f    = UA_EMIT;
            end
            UA_CHK_ROW: begin
                u.mem_op   = MEM_RD;
                u.addr_sel = AD_ROW;
                u.v_op     = CNT_ZERO;
                u.tgt_t    = UA_CHK_TEST;
            end
            UA_CHK_TEST: begin
                u.row_ld   = 1'b1;
                u.flag_sel = FL_ROW_ZERO;
                u.tgt_t    = UA_FAIL;
                u.tgt_f    = UA_CHK_BIT;
            end
            UA_CHK_BIT: begin
                u.flag_sel = FL_VBIT;
                u.tgt_t    = UA_CHK_COL;
                u.tgt_f    = UA_CHK_VNEXT;
            end
            UA_CHK_COL: begin
                u.mem_op   = MEM_RD;
                u.addr_sel = AD_COL;
                u.tgt_t    = UA_CHK_CMP;
            end
            UA_CHK_CMP: begin
                u.flag_sel = FL_MISMATCH;
                u.tgt_t    = UA_FAIL;
                u.tgt_f    = UA_CHK_VNEXT;
            end
            UA_CHK_VNEXT: begin
                u.v_op     = CNT_INC;
                u.flag_sel = FL_V_LAST;
                u.tgt_t    = UA_CHK_WNEXT;
                u.tgt_f    = UA_CHK_BIT;
            end
            UA_CHK_WNEXT: begin
                u.w_op     = CNT_INC;
                u.flag_sel = FL_W_LAST;
                u.tgt_t    = UA_CHK_ANEXT;
                u.tgt_f    = UA_CHK_ROW;
            end
            UA_CHK_ANEXT: begin
                u.a_op     = CNT_INC;
                u.w_op     = CNT_ZERO;
                u.flag_sel = FL_A_LAST;
                u.tgt_t    = UA_PASS;
                u.tgt_f    = UA_CHK_ROW;
            end
            UA_PASS: begin
                u.res_op = RES_HOLDS;
                u.tgt_t  = UA_EMIT;
            end
            UA_FAIL: begin
                u.tgt_t = UA_EMIT;
            end
            default: begin
                u.tgt_t = UA_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: hdl/kd45c_ram.sv
// ============================================================================
// kd45c_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ============================================================================
module kd45c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/kd45c_useq.sv
// ============================================================================
// kd45c_useq
// Microsequencer: step counter, control store and branch/dispatch logic.
// ============================================================================
module kd45c_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kd45c_pkg::t_flags i_flags,
    output kd45c_pkg::t_uword o_ctl
);

    kd45c_pkg::t_upc   r_upc;
    kd45c_pkg::t_upc   n_upc;
    kd45c_pkg::t_uword w_uw;
    logic              w_flag;

    assign w_uw  = kd45c_pkg::f_ucode(r_upc);
    assign o_ctl = w_uw;

    always_comb begin
        case (w_uw.flag_sel)
            kd45c_pkg::FL_ONE:      w_flag = 1'b1;
            kd45c_pkg::FL_ACCEPT:   w_flag = i_flags.accept;
            kd45c_pkg::FL_CLR_LAST: w_flag = i_flags.clr_last;
            kd45c_pkg::FL_BOOT:     w_flag = i_flags.boot;
            kd45c_pkg::FL_OUT_FREE: w_flag = i_flags.out_free;
            kd45c_pkg::FL_ROW_ZERO: w_flag = i_flags.row_zero;
            kd45c_pkg::FL_VBIT:     w_flag = i_flags.vbit;
            kd45c_pkg::FL_MISMATCH: w_flag = i_flags.mismatch;
            kd45c_pkg::FL_V_LAST:   w_flag = i_flags.v_last;
            kd45c_pkg::FL_W_LAST:   w_flag = i_flags.w_last;
            kd45c_pkg::FL_A_LAST:   w_flag = i_flags.a_last;
            default:                w_flag = 1'b1;
        endcase
    end

    always_comb begin
        if (w_uw.jump == kd45c_pkg::JK_DISPATCH) begin
            n_upc = i_flags.accept
                  ? kd45c_pkg::f_dispatch(i_flags.in_op, i_flags.in_err, i_flags.vacuous)
                  : w_uw.tgt_f;
        end else begin
            n_upc = w_flag ? w_uw.tgt_t : w_uw.tgt_f;
        end
    end

    // reset enters the store clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= kd45c_pkg::UA_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

FILE: hdl/kd45c_dpath.sv
// ============================================================================
// kd45c_dpath
// Datapath: relation store, walk counters, row holding register, results.
// ============================================================================
module kd45c_dpath #(
    parameter int MAX_AGENTS = kd45c_pkg::MAX_AGENTS_DEF,
    parameter int MAX_WORLDS = kd45c_pkg::MAX_WORLDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kd45c_pkg::t_uword           i_ctl,
    input  logic                        i_accept,
    input  logic                        i_out_free,
    input  kd45c_pkg::t_in_item         i_in,
    input  logic [kd45c_pkg::CNT_W-1:0] i_agents,
    input  logic [kd45c_pkg::CNT_W-1:0] i_worlds,
    output kd45c_pkg::t_flags           o_flags,
    output kd45c_pkg::t_out_item        o_result
);

    localparam int ROWS  = MAX_AGENTS * MAX_WORLDS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int A_W   = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int W_W   = $clog2(MAX_WORLDS);
    localparam int CW    = kd45c_pkg::CNT_W;
    localparam int PW    = 2 * kd45c_pkg::CNT_W;

    logic [1:0]            r_op;
    logic [2:0]            r_agent;
    logic [4:0]            r_from;
    logic [4:0]            r_to;
    logic                  r_err;
    logic                  r_rel;
    logic                  r_holds;
    logic                  r_boot;
    logic [MAX_WORLDS-1:0] r_row;
    logic [A_W-1:0]        r_a;
    logic [W_W-1:0]        r_w;
    logic [W_W-1:0]        r_v;
    logic [ROW_W-1:0]      r_clr;

    logic [A_W-1:0]        n_a;
    logic [W_W-1:0]        n_w;
    logic [W_W-1:0]        n_v;
    logic [ROW_W-1:0]      n_clr;

    logic [MAX_WORLDS-1:0] w_mask;
    logic [MAX_WORLDS-1:0] w_rdata;
    logic [MAX_WORLDS-1:0] w_masked;
    logic [MAX_WORLDS-1:0] w_onehot;
    logic [MAX_WORLDS-1:0] w_rel_shift;
    logic [MAX_WORLDS-1:0] w_wdata;
    logic [CW-1:0]         w_sel_a;
    logic [CW-1:0]         w_sel_w;
    logic [PW-1:0]         w_addr_full;
    logic [ROW_W-1:0]      w_addr;
    logic                  w_we;
    logic                  w_re;
    logic                  w_rel_live;
    logic                  w_in_err;

    always_comb begin
        for (int i = 0; i < MAX_WORLDS; i++) begin
            w_mask[i] = (CW'(i) < i_worlds);
        end
    end

    always_comb begin
        case (i_ctl.addr_sel)
            kd45c_pkg::AD_IN: begin
                w_sel_a = CW'(i_in.agent);
                w_sel_w = CW'(i_in.src_world);
            end
            kd45c_pkg::AD_ITEM: begin
                w_sel_a = CW'(r_agent);
                w_sel_w = CW'(r_from);
            end
            kd45c_pkg::AD_ROW: begin
                w_sel_a = CW'(r_a);
                w_sel_w = CW'(r_w);
            end
            kd45c_pkg::AD_COL: begin
                w_sel_a = CW'(r_a);
                w_sel_w = CW'(r_v);
            end
            default: begin
                w_sel_a = '0;
                w_sel_w = '0;
            end
        endcase
    end

    assign w_addr_full = PW'(w_sel_a) * PW'(MAX_WORLDS) + PW'(w_sel_w);
    assign w_addr      = (i_ctl.addr_sel == kd45c_pkg::AD_CLR) ? r_clr
                                                                : w_addr_full[ROW_W-1:0];

    assign w_onehot    = {{(MAX_WORLDS-1){1'b0}}, 1'b1} << r_to;
    assign w_rel_shift = w_rdata >> r_to;
    assign w_rel_live  = (r_op == kd45c_pkg::OP_QUERY) && w_rel_shift[0];
    assign w_wdata     = (i_ctl.wdata_sel == kd45c_pkg::WD_SET) ? (w_rdata | w_onehot) : '0;
    assign w_we        = (i_ctl.mem_op == kd45c_pkg::MEM_WR)
                      && ((i_ctl.wdata_sel == kd45c_pkg::WD_ZERO)
                          || (r_op == kd45c_pkg::OP_SET));
    assign w_re        = (i_ctl.mem_op == kd45c_pkg::MEM_RD);
    assign w_masked    = w_rdata & w_mask;

    kd45c_ram #(
        .WIDTH (MAX_WORLDS),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_in_err = (CW'(i_in.agent) >= i_agents)
                   || (CW'(i_in.src_world) >= i_worlds)
                   || (CW'(i_in.dst_world) >= i_worlds);

    always_comb begin
        case (i_ctl.a_op)
            kd45c_pkg::CNT_ZERO: n_a = '0;
            kd45c_pkg::CNT_INC:  n_a = r_a + A_W'(1);
            default:             n_a = r_a;
        endcase
        case (i_ctl.w_op)
            kd45c_pkg::CNT_ZERO: n_w = '0;
            kd45c_pkg::CNT_INC:  n_w = r_w + W_W'(1);
            default:             n_w = r_w;
        endcase
        case (i_ctl.v_op)
            kd45c_pkg::CNT_ZERO: n_v = '0;
            kd45c_pkg::CNT_INC:  n_v = r_v + W_W'(1);
            default:             n_v = r_v;
        endcase
        case (i_ctl.clr_op)
            kd45c_pkg::CNT_ZERO: n_clr = '0;
            kd45c_pkg::CNT_INC:  n_clr = r_clr + ROW_W'(1);
            default:             n_clr = r_clr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_w    <= '0;
            r_v    <= '0;
            r_clr  <= '0;
            r_boot <= 1'b1;
        end else begin
            r_a   <= n_a;
            r_w   <= n_w;
            r_v   <= n_v;
            r_clr <= n_clr;
            if (i_ctl.res_op == kd45c_pkg::RES_BOOT_OFF) begin
                r_boot <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_ld) begin
            r_row <= w_masked;
        end
        case (i_ctl.res_op)
            kd45c_pkg::RES_LOAD: begin
                if (i_accept) begin
                    r_op    <= i_in.operation;
                    r_agent <= i_in.agent;
                    r_from  <= i_in.src_world;
                    r_to    <= i_in.dst_world;
                    r_rel   <= 1'b0;
                    r_err   <= w_in_err && ((i_in.operation == kd45c_pkg::OP_SET)
                                            || (i_in.operation == kd45c_pkg::OP_QUERY));
                    r_holds <= (i_in.operation == kd45c_pkg::OP_CHECK)
                            && ((i_agents == '0) || (i_worlds == '0));
                end
            end
            kd45c_pkg::RES_REL:   r_rel   <= w_rel_live;
            kd45c_pkg::RES_HOLDS: r_holds <= 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_flags.accept   = i_accept;
        o_flags.out_free = i_out_free;
        o_flags.clr_last = (r_clr == ROW_W'(ROWS - 1));
        o_flags.boot     = r_boot;
        o_flags.row_zero = (w_masked == '0);
        o_flags.vbit     = r_row[r_v];
        o_flags.mismatch = (w_masked != r_row);
        o_flags.v_last   = (CW'(r_v) == (i_worlds - CW'(1)));
        o_flags.w_last   = (CW'(r_w) == (i_worlds - CW'(1)));
        o_flags.a_last   = (CW'(r_a) == (i_agents - CW'(1)));
        o_flags.in_op    = i_in.operation;
        o_flags.in_err   = w_in_err;
        o_flags.vacuous  = (i_agents == '0) || (i_worlds == '0);
    end

    assign o_result.related     = (i_ctl.res_op == kd45c_pkg::RES_REL) ? w_rel_live : r_rel;
    assign o_result.kd45_holds  = r_holds;
    assign o_result.index_error = r_err;

endmodule

FILE: hdl/kripke_relation_store_kd45_check_unit.sv
// ============================================================================
// kripke_relation_store_kd45_check_unit
// Per-agent relation store with set, query, clear and KD45 property check.
// ============================================================================
// One item at a time, one result per item. Set and query read the row; a set
// then writes it back with the new bit, and both give the result. Clear zeroes
// one store row per cycle through the single RAM port, and the same pass runs
// after reset before the first item is taken. A check reads, for each agent
// and world in use, the row and then the row of each world set in it; it
// stops at the first failing row.
// ============================================================================
module kripke_relation_store_kd45_check_unit #(
    parameter int MAX_AGENTS = kd45c_pkg::MAX_AGENTS_DEF,
    parameter int MAX_WORLDS = kd45c_pkg::MAX_WORLDS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  kd45c_pkg::t_in_item              i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output kd45c_pkg::t_out_item             o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kd45c_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kd45c_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = kd45c_pkg::CNT_W;

    logic [kd45c_pkg::AGENT_CNT_W-1:0] r_agent_count;
    logic [kd45c_pkg::WORLD_CNT_W-1:0] r_world_count;
    logic                              r_out_valid;
    kd45c_pkg::t_out_item              r_out;

    kd45c_pkg::t_uword                 w_ctl;
    kd45c_pkg::t_flags                 w_flags;
    kd45c_pkg::t_out_item              w_result;
    logic [CW-1:0]                     w_agents;
    logic [CW-1:0]                     w_worlds;
    logic                              w_in_acc;
    logic                              w_cfg_acc;
    logic                              w_out_free;
    logic                              w_out_load;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = !w_ctl.take_in;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = w_ctl.emit && w_out_free;

    // counts saturate at the store size
    assign w_agents = (CW'(r_agent_count) > CW'(MAX_AGENTS)) ? CW'(MAX_AGENTS)
                                                             : CW'(r_agent_count);
    assign w_worlds = (CW'(r_world_count) > CW'(MAX_WORLDS)) ? CW'(MAX_WORLDS)
                                                             : CW'(r_world_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_agent_count <= kd45c_pkg::AGENT_CNT_W'(1);
            r_world_count <= kd45c_pkg::WORLD_CNT_W'(1);
        end else if (w_cfg_acc) begin
            if (i_cfg_index == kd45c_pkg::CFG_AGENT_COUNT) begin
                r_agent_count <= i_cfg_data[kd45c_pkg::AGENT_CNT_W-1:0];
            end else if (i_cfg_index == kd45c_pkg::CFG_WORLD_COUNT) begin
                r_world_count <= i_cfg_data[kd45c_pkg::WORLD_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    kd45c_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    kd45c_dpath #(
        .MAX_AGENTS (MAX_AGENTS),
        .MAX_WORLDS (MAX_WORLDS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_accept   (w_in_acc),
        .i_out_free (w_out_free),
        .i_in       (i_in),
        .i_agents   (w_agents),
        .i_worlds   (w_worlds),
        .o_flags    (w_flags),
        .o_result   (w_result)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctl.emit))
        else $error("result loaded outside an emit step");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.index_error) |-> (!o_out.related && !o_out.kd45_holds))
        else $error("flagged result carries data");

    a_holds_not_related: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kd45_holds) |-> !o_out.related)
        else $error("check result carries a query bit");
`endif

endmodule

FILE: sim/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the KD45 relation store and property check unit.
// Keeps a shadow copy of the per-agent relation rows and the count registers,
// predicts the result of every input transfer, and compares each output
// transfer field by field. Directed items come first: reset defaults, count
// saturation, zero counts, spare register indexes and bits beyond the worlds
// in use. After them come a full-size check, an output hold-off that backs up
// the input, and a stretch with no idling. Random phases then build KD45
// relations, some of them damaged, mixed with noise items, over many count
// settings.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEM_TARGET     = 1450;
    localparam int IDLE_PCT        = 19;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_A           = kd45c_pkg::MAX_AGENTS_DEF;
    localparam int MAX_W           = kd45c_pkg::MAX_WORLDS_DEF;
    localparam int ROW_TOTAL       = MAX_A * MAX_W;

    localparam logic [kd45c_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [kd45c_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    kd45c_pkg::t_in_item              i_in        = '0;
    logic                             i_out_stall = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic [kd45c_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [kd45c_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    kd45c_pkg::t_out_item             o_out;
    logic                             o_cfg_ready;

    logic [MAX_W-1:0]     relation_shadow [ROW_TOTAL];
    logic [3:0]           agent_count_reg = 4'd1;
    logic [5:0]           world_count_reg = 6'd1;
    kd45c_pkg::t_out_item expected_results [$];

    int   items_sent    = 0;
    int   error_count   = 0;
    int   cycle_count   = 0;
    logic no_idle       = 1'b0;
    logic receiver_hold = 1'b0;
    event hold_off_go;

    kripke_relation_store_kd45_check_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver hold-off, counted here
    always begin
        @(hold_off_go);
        receiver_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        receiver_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= receiver_hold || (!no_idle && ($urandom_range(99) < IDLE_PCT));
    end

    always @(posedge i_clk) begin
        kd45c_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation waiting: %p", o_out);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out.related !== want.related) begin
                    $error("related: expected %0b, got %0b", want.related, o_out.related);
                    error_count++;
                end
                if (o_out.kd45_holds !== want.kd45_holds) begin
                    $error("kd45_holds: expected %0b, got %0b",
                           want.kd45_holds, o_out.kd45_holds);
                    error_count++;
                end
                if (o_out.index_error !== want.index_error) begin
                    $error("index_error: expected %0b, got %0b",
                           want.index_error, o_out.index_error);
                    error_count++;
                end
            end
        end
    end

    function automatic int agents_in_use();
        return (agent_count_reg > MAX_A) ? MAX_A : int'(agent_count_reg);
    endfunction

    function automatic int worlds_in_use();
        return (world_count_reg > MAX_W) ? MAX_W : int'(world_count_reg);
    endfunction

    function automatic logic kd45_holds_now();
        int               na;
        int               nw;
        logic [MAX_W-1:0] mask;
        logic [MAX_W-1:0] row;
        na   = agents_in_use();
        nw   = worlds_in_use();
        mask = (nw >= MAX_W) ? '1 : ((32'd1 << nw) - 32'd1);
        for (int a = 0; a < na; a++) begin
            for (int w = 0; w < nw; w++) begin
                row = relation_shadow[a * MAX_W + w] & mask;
                if (row == '0) return 1'b0;
                for (int v = 0; v < nw; v++) begin
                    if (row[v] && ((relation_shadow[a * MAX_W + v] & mask) != row))
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic kd45c_pkg::t_out_item predict_result(input kd45c_pkg::t_in_item it);
        kd45c_pkg::t_out_item res;
        int                   r;
        res = '0;
        case (it.operation)
            kd45c_pkg::OP_CLEAR: begin
                for (int i = 0; i < ROW_TOTAL; i++) relation_shadow[i] = '0;
            end
            kd45c_pkg::OP_CHECK: begin
                res.kd45_holds = kd45_holds_now();
            end
            default: begin
                if (int'(it.agent) >= agents_in_use() || int'(it.src_world) >= worlds_in_use()
                        || int'(it.dst_world) >= worlds_in_use()) begin
                    res.index_error = 1'b1;
                end else begin
                    r = int'(it.agent) * MAX_W + int'(it.src_world);
                    if (it.operation == kd45c_pkg::OP_SET) relation_shadow[r][it.dst_world] = 1'b1;
                    else res.related = relation_shadow[r][it.dst_world];
                end
            end
        endcase
        return res;
    endfunction

    function automatic kd45c_pkg::t_in_item make_item(input logic [1:0] op,
                                                      input logic [2:0] agent,
                                                      input logic [4:0] from,
                                                      input logic [4:0] to);
        kd45c_pkg::t_in_item it;
        it.operation = op;
        it.agent     = agent;
        it.src_world = from;
        it.dst_world = to;
        return it;
    endfunction

    // in-range fields where the counts allow it, otherwise anything
    function automatic kd45c_pkg::t_in_item pick_item(input logic [1:0] op, input bit in_range);
        int na;
        int nw;
        na = agents_in_use();
        nw = worlds_in_use();
        if (in_range && na > 0 && nw > 0)
            return make_item(op, 3'($urandom_range(0, na - 1)),
                             5'($urandom_range(0, nw - 1)), 5'($urandom_range(0, nw - 1)));
        return make_item(op, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                         5'($urandom_range(0, 31)));
    endfunction

    task automatic send_item(input kd45c_pkg::t_in_item it);
        if (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        expected_results = {expected_results, predict_result(it)};
        items_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_counts(input logic [5:0] agents_raw, input logic [5:0] worlds_raw,
                              input bit poke_spare);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= kd45c_pkg::CFG_AGENT_COUNT;
        i_cfg_data  <= agents_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        agent_count_reg = agents_raw[3:0];
        i_cfg_index <= kd45c_pkg::CFG_WORLD_COUNT;
        i_cfg_data  <= worlds_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        world_count_reg = worlds_raw;
        if (poke_spare) begin
            i_cfg_index <= CFG_SPARE_2;
            i_cfg_data  <= 6'($urandom_range(0, 63));
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_index <= CFG_SPARE_3;
            i_cfg_data  <= 6'($urandom_range(0, 63));
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // worlds fall into groups; every world of a group points at the same
    // nonempty target set drawn from that group, less the sets dropped by drop_pct
    task automatic send_kd45_relation(input int agent, input int nw, input int max_pick,
                                      input int drop_pct);
        int               grp [MAX_W];
        logic [MAX_W-1:0] members [MAX_W];
        logic [MAX_W-1:0] target [MAX_W];
        int               ngrp;
        int               picked;
        int               start;
        int               v;
        int               w;
        ngrp = $urandom_range(1, nw);
        for (int g = 0; g < MAX_W; g++) begin
            members[g] = '0;
            target[g]  = '0;
        end
        for (int i = 0; i < nw; i++) begin
            grp[i] = $urandom_range(0, ngrp - 1);
            members[grp[i]][i] = 1'b1;
        end
        for (int g = 0; g < ngrp; g++) begin
            picked = 0;
            start  = $urandom_range(0, nw - 1);
            for (int k = 0; k < nw; k++) begin
                v = (start + k) % nw;
                if (members[g][v] && (target[g] == '0
                        || (picked < max_pick && $urandom_range(1) == 1))) begin
                    target[g][v] = 1'b1;
                    picked++;
                end
            end
        end
        start = $urandom_range(0, nw - 1);
        for (int k = 0; k < nw; k++) begin
            w = (start + k) % nw;
            for (int i = 0; i < nw; i++) begin
                if (target[grp[w]][i] && ($urandom_range(99) >= drop_pct))
                    send_item(make_item(kd45c_pkg::OP_SET, 3'(agent), 5'(w), 5'(i)));
            end
        end
    endtask

    task automatic send_kd45_sequence();
        int na;
        int nw;
        int drop_pct;
        na       = agents_in_use();
        nw       = worlds_in_use();
        drop_pct = ($urandom_range(99) < 80) ? 0 : 10;
        send_item(pick_item(kd45c_pkg::OP_CLEAR, 1'b0));
        if (na > 0 && nw > 0) begin
            for (int a = 0; a < na; a++)
                send_kd45_relation(a, nw, (nw <= 8) ? 3 : 1, drop_pct);
        end
        if ($urandom_range(99) < 25) send_item(pick_item(kd45c_pkg::OP_SET, 1'b1));
        repeat (3) send_item(pick_item(kd45c_pkg::OP_QUERY, 1'b1));
        send_item(pick_item(kd45c_pkg::OP_QUERY, 1'b0));
        send_item(pick_item(kd45c_pkg::OP_CHECK, 1'b0));
    endtask

    task automatic send_noise(input int count);
        logic [1:0] op;
        repeat (count) begin
            if ($urandom_range(99) < 10) op = kd45c_pkg::OP_CLEAR;
            else op = 2'($urandom_range(1, 3));
            send_item(pick_item(op, $urandom_range(1) == 1));
        end
    endtask

    task automatic test_reset_defaults();
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_SET, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_SET, 1, 0, 0));
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 1, 0));
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 0, 1));
    endtask

    task automatic test_count_extremes();
        set_counts(6'h3F, 6'h3F, 1'b1);
        send_item(make_item(kd45c_pkg::OP_SET, 7, 31, 31));
        send_item(make_item(kd45c_pkg::OP_QUERY, 7, 31, 31));
        send_item(make_item(kd45c_pkg::OP_QUERY, 7, 31, 30));
        send_item(make_item(kd45c_pkg::OP_CHECK, 7, 31, 31));
        send_item(make_item(kd45c_pkg::OP_CLEAR, 7, 31, 31));
        send_item(make_item(kd45c_pkg::OP_QUERY, 7, 31, 31));
        set_counts(6'd0, 6'd32, 1'b0);
        send_item(make_item(kd45c_pkg::OP_SET, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
        set_counts(6'd1, 6'd0, 1'b0);
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 0, 0));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
    endtask

    task automatic test_hidden_bits();
        set_counts(6'd1, 6'd8, 1'b0);
        send_item(make_item(kd45c_pkg::OP_SET, 0, 0, 6));
        set_counts(6'd1, 6'd4, 1'b0);
        for (int w = 0; w < 4; w++) send_item(make_item(kd45c_pkg::OP_SET, 0, 5'(w), 0));
        send_item(make_item(kd45c_pkg::OP_QUERY, 0, 0, 6));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
    endtask

    task automatic test_full_size();
        set_counts(6'd8, 6'd32, 1'b0);
        send_item(make_item(kd45c_pkg::OP_CLEAR, 0, 0, 0));
        for (int a = 0; a < MAX_A; a++) send_kd45_relation(a, MAX_W, 1, 0);
        send_item(pick_item(kd45c_pkg::OP_QUERY, 1'b1));
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
    endtask

    task automatic test_output_pressure();
        set_counts(6'd2, 6'd4, 1'b0);
        -> hold_off_go;
        repeat (30) begin
            send_item(pick_item(($urandom_range(1) == 1) ? kd45c_pkg::OP_SET
                                                         : kd45c_pkg::OP_QUERY, 1'b1));
        end
        send_item(make_item(kd45c_pkg::OP_CHECK, 0, 0, 0));
    endtask

    task automatic test_steady_stream();
        no_idle <= 1'b1;
        set_counts(6'd3, 6'd6, 1'b0);
        repeat (4) send_kd45_sequence();
        no_idle <= 1'b0;
    endtask

    task automatic test_random_phases();
        int          roll;
        logic [5:0]  agents_raw;
        logic [5:0]  worlds_raw;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(99);
            agents_raw = 6'($urandom_range(1, 3));
            worlds_raw = 6'($urandom_range(1, 8));
            if (roll >= 90) worlds_raw = 6'($urandom_range(0, 63));
            else if (roll >= 80) agents_raw = 6'($urandom_range(0, 63));
            set_counts(agents_raw, worlds_raw, $urandom_range(99) < 20);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(99) < 75) send_kd45_sequence();
                else send_noise($urandom_range(5, 20));
            end
            send_item(pick_item(kd45c_pkg::OP_CHECK, 1'b0));
        end
    endtask

    initial begin
        for (int i = 0; i < ROW_TOTAL; i++) relation_shadow[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_count_extremes();
        test_hidden_bits();
        test_full_size();
        test_output_pressure();
        test_steady_stream();
        test_random_phases();
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/kd45c_pkg.sv
hdl/kd45c_ram.sv
hdl/kd45c_useq.sv
hdl/kd45c_dpath.sv
hdl/kripke_relation_store_kd45_check_unit.sv
sim/testbench.sv
